>>> rtl/mngdf_pkg.sv
// Package for the MNG chunk deframer: phase and status codes, the result
// record and the stream constants. It has no dependencies.
package mngdf_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_HALT
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SIG      = 3'd1,
    ST_NOT_MHDR     = 3'd2,
    ST_BAD_MHDR_LEN = 3'd3,
    ST_TOO_LONG     = 3'd4
  } status_e;

  // One tagged output byte.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [31:0] packet_number;
    logic        packet_start;
    logic        packet_end;
    logic        begin_of_stream;
    logic        end_of_stream;
    status_e     status;
  } result_t;

  localparam logic [31:0] KIND_MHDR      = 32'h4d48_4452;
  localparam logic [31:0] KIND_MEND      = 32'h4d45_4e44;
  localparam logic [31:0] MHDR_LENGTH    = 32'd28;
  localparam logic [31:0] HEADER_LAST    = 32'd47;
  localparam logic [31:0] CHUNK_OVERHEAD = 32'd12;
  localparam logic [31:0] SIG_BYTES      = 32'd8;

  localparam logic [7:0] MNG_SIG [8] = '{
    8'h8A, 8'h4D, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

endpackage

>>> rtl/mngdf_framer.sv
// Framing state of the MNG chunk deframer: tracks the byte position in the
// current packet and tags each byte. Depends on mngdf_pkg.
module mngdf_framer #(
  parameter int PACKET_NUMBER_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  output mngdf_pkg::result_t  result_o
);

  localparam int PNB = PACKET_NUMBER_BITS;

  mngdf_pkg::phase_e  phase_q, phase_d;
  mngdf_pkg::status_e fault_q, fault_d;
  logic [31:0]        pos_q, pos_d;
  logic [31:0]        size_q, size_d;
  logic [31:0]        kind_q, kind_d;
  logic [PNB-1:0]     count_q, count_d;

  mngdf_pkg::status_e fault;
  logic               last_byte;
  logic [31:0]        kind_shift;
  logic [31:0]        chunk_last;
  logic [63:0]        count_ext;

  assign kind_shift = {kind_q[23:0], data_byte_i};
  assign chunk_last = {1'b0, size_q[30:0]} + (mngdf_pkg::CHUNK_OVERHEAD - 32'd1);
  assign count_ext  = 64'(count_q);

  // Fault detection and packet end for the current byte.
  always_comb begin
    fault     = mngdf_pkg::ST_OK;
    last_byte = 1'b0;
    unique case (phase_q)
      mngdf_pkg::PH_HEADER: begin
        if (pos_q < mngdf_pkg::SIG_BYTES) begin
          if (data_byte_i != mngdf_pkg::MNG_SIG[pos_q[2:0]]) begin
            fault = mngdf_pkg::ST_BAD_SIG;
          end
        end else if (pos_q == 32'd15) begin
          if (kind_shift != mngdf_pkg::KIND_MHDR) begin
            fault = mngdf_pkg::ST_NOT_MHDR;
          end else if (size_q != mngdf_pkg::MHDR_LENGTH) begin
            fault = mngdf_pkg::ST_BAD_MHDR_LEN;
          end
        end
        last_byte = (pos_q == mngdf_pkg::HEADER_LAST);
      end
      mngdf_pkg::PH_CHUNK: begin
        if (pos_q == 32'd0 && data_byte_i[7]) begin
          fault = mngdf_pkg::ST_TOO_LONG;
        end
        last_byte = (pos_q >= mngdf_pkg::CHUNK_OVERHEAD - 32'd1) && (pos_q == chunk_last);
      end
      default: begin
        fault     = mngdf_pkg::ST_OK;
        last_byte = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    fault_d = fault_q;
    pos_d   = pos_q;
    size_d  = size_q;
    kind_d  = kind_q;
    count_d = count_q;
    if (step_i && phase_q != mngdf_pkg::PH_HALT) begin
      if (phase_q == mngdf_pkg::PH_HEADER) begin
        if (pos_q >= 32'd8 && pos_q < 32'd12) begin
          size_d = {size_q[23:0], data_byte_i};
        end else if (pos_q >= 32'd12 && pos_q < 32'd16) begin
          kind_d = kind_shift;
        end
      end else begin
        if (pos_q == 32'd0) begin
          size_d = {24'd0, data_byte_i};
        end else if (pos_q < 32'd4) begin
          size_d = {1'b0, size_q[22:0], data_byte_i};
        end else if (pos_q == 32'd4) begin
          kind_d = {24'd0, data_byte_i};
        end else if (pos_q < 32'd8) begin
          kind_d = kind_shift;
        end
      end
      if (fault != mngdf_pkg::ST_OK) begin
        fault_d = fault;
        phase_d = mngdf_pkg::PH_HALT;
      end else if (last_byte) begin
        count_d = count_q + {{(PNB-1){1'b0}}, 1'b1};
        pos_d   = 32'd0;
        phase_d = mngdf_pkg::PH_CHUNK;
      end else begin
        pos_d = pos_q + 32'd1;
      end
    end
  end

  // Tags for the current byte.
  always_comb begin
    result_o.out_byte        = data_byte_i;
    result_o.packet_number   = count_ext[31:0];
    result_o.packet_start    = 1'b0;
    result_o.packet_end      = 1'b0;
    result_o.begin_of_stream = 1'b0;
    result_o.end_of_stream   = 1'b0;
    result_o.status          = (fault != mngdf_pkg::ST_OK) ? fault : fault_q;
    if (phase_q != mngdf_pkg::PH_HALT && fault == mngdf_pkg::ST_OK) begin
      result_o.packet_start = (pos_q == 32'd0);
      result_o.packet_end   = last_byte;
      if (last_byte) begin
        result_o.begin_of_stream = (phase_q == mngdf_pkg::PH_HEADER) ||
                                   (kind_q == mngdf_pkg::KIND_MHDR);
        result_o.end_of_stream   = (phase_q == mngdf_pkg::PH_CHUNK) &&
                                   (kind_q == mngdf_pkg::KIND_MEND);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mngdf_pkg::PH_HEADER;
      fault_q <= mngdf_pkg::ST_OK;
      pos_q   <= '0;
      size_q  <= '0;
      kind_q  <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      fault_q <= fault_d;
      pos_q   <= pos_d;
      size_q  <= size_d;
      kind_q  <= kind_d;
      count_q <= count_d;
    end
  end

endmodule

>>> rtl/mng_chunk_deframer.sv
// Top level of the MNG chunk deframer: framing state plus an output register
// and a skid register. Depends on mngdf_pkg and mngdf_framer.
//
// Usage: raw MNG stream bytes arrive on the input channel (in_valid_i,
// in_stall_o, data_byte_i), one byte per transfer. Every byte leaves on the
// output channel (out_valid_o, out_stall_i and the payload ports) unchanged,
// tagged with its packet number, start and end marks, begin and end of
// stream flags, and a status code. Packet 0 is the 8-byte signature plus the
// 40-byte MHDR chunk; every later chunk is one packet of length + 12 bytes.
// Each byte is registered in the output register, or in the skid register
// while the output is held. Throughput: one byte per cycle while in_stall_o
// is low, with a combinational framing update (position counter, chunk end).
// When the receiver stalls, the output register holds its byte and one more
// byte is caught in the skid register; only then is in_stall_o raised, and
// it is driven from a register alone.
// A fault latches its status code; framing halts but bytes keep flowing with
// all marks cleared and the packet number frozen. Only reset clears a fault.
// Reset empties both registers and restarts the search for the signature.
module mng_chunk_deframer #(
  parameter int PACKET_NUMBER_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [31:0] packet_number_o,
  output logic        packet_start_o,
  output logic        packet_end_o,
  output logic        begin_of_stream_o,
  output logic        end_of_stream_o,
  output logic [2:0]  status_o
);

  mngdf_pkg::result_t result;
  mngdf_pkg::result_t out_q, out_d;
  mngdf_pkg::result_t skid_q, skid_d;
  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  logic               in_xfer;
  logic               out_xfer;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !skid_valid_q;
  assign out_xfer   = out_valid_q && !out_stall_i;

  mngdf_framer #(
    .PACKET_NUMBER_BITS(PACKET_NUMBER_BITS)
  ) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_xfer),
    .data_byte_i(data_byte_i),
    .result_o   (result)
  );

  // Output register with skid: a new result goes to the output register when
  // it is empty or being drained, otherwise into the skid register.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid_q || out_xfer) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_q.out_byte;
  assign packet_number_o   = out_q.packet_number;
  assign packet_start_o    = out_q.packet_start;
  assign packet_end_o      = out_q.packet_end;
  assign begin_of_stream_o = out_q.begin_of_stream;
  assign end_of_stream_o   = out_q.end_of_stream;
  assign status_o          = out_q.status;

  // The skid register is only ever filled behind a held output byte.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a byte while the output register is empty");

  // Once a fault is reported, no framing marks are shown.
  a_fault_no_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != mngdf_pkg::ST_OK) |->
      !(packet_start_o || packet_end_o || begin_of_stream_o || end_of_stream_o))
    else $error("framing mark shown on a faulted byte");

  // Stream flags are only reported on the last byte of a packet.
  a_flags_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (begin_of_stream_o || end_of_stream_o)) |-> packet_end_o)
    else $error("stream flag outside a packet end");

  // A latched fault never clears while reset is inactive.
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && status_o != mngdf_pkg::ST_OK) |=>
      (!out_valid_o || status_o != mngdf_pkg::ST_OK))
    else $error("fault status cleared without reset");

endmodule
